/* hdl/mpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_pkg: shared types and constants of the multi-press classifier
// Phase codes, register indexes, reset values and the state and result
// structs passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package mpc_pkg;

    // elapsed-tick counter width
    localparam int TIMER_WIDTH = 24;
    // configuration register width
    localparam int CFG_W       = 24;
    // compare width covering both the counter and the registers
    localparam int CMP_W       = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    localparam int CFG_IDX_W   = 2;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE    = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 24'd100000;
    localparam logic [CFG_W-1:0] WINDOW_RESET   = 24'd500000;
    localparam logic [CFG_W-1:0] PAUSE_RESET    = 24'd1500000;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ONCE   = 3'd1,
        PH_TWICE  = 3'd2,
        PH_THRICE = 3'd3,
        PH_PAUSE  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_TRIPLE = 2'd3
    } event_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] window_ticks;
        logic [CFG_W-1:0] pause_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t                 phase;
        logic                   press_pending;
        logic [TIMER_WIDTH-1:0] elapsed_ticks;
        logic                   single_flag;
        logic                   double_flag;
        logic                   triple_flag;
    } state_t;

    typedef struct packed {
        logic                   press_ignored;
        event_t                 completed_event;
        logic                   triple_toggle;
        logic                   double_toggle;
        logic                   single_toggle;
        phase_t                 phase;
    } result_t;

endpackage
`default_nettype wire

/* hdl/mpc_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_step: one tick of the press latch and the phase machine
// Pure combinational next-state and result logic for one input word.
// ----------------------------------------------------------------------------
module mpc_step (
    input  mpc_pkg::state_t  st,
    input  mpc_pkg::cfg_t    cfg,
    input  logic             button_edge,
    output mpc_pkg::state_t  st_next,
    output mpc_pkg::result_t res
);
    import mpc_pkg::*;

    localparam logic [TIMER_WIDTH-1:0] CNT_MAX = {TIMER_WIDTH{1'b1}};

    logic [TIMER_WIDTH-1:0] elapsed;
    logic                   pending;
    logic [CMP_W-1:0]       elapsed_x;
    logic                   debounced;
    logic                   window_done;
    logic                   pause_done;
    logic                   ready;
    state_t                 nxt;
    event_t                 ev;
    logic                   ignored;

    // press latch and saturating elapsed counter
    always_comb begin
        pending = st.press_pending;
        elapsed = st.elapsed_ticks;
        if (button_edge && !st.press_pending) begin
            pending = 1'b1;
            elapsed = '0;
        end else if (st.elapsed_ticks != CNT_MAX) begin
            elapsed = st.elapsed_ticks + TIMER_WIDTH'(1);
        end
    end

    // compares against the updated counter
    assign elapsed_x   = CMP_W'(elapsed);
    assign debounced   = elapsed_x >= CMP_W'(cfg.debounce_ticks);
    assign window_done = elapsed_x >= CMP_W'(cfg.window_ticks);
    assign pause_done  = elapsed_x >= CMP_W'(cfg.pause_ticks);
    assign ready       = pending && debounced;

    // phase machine
    always_comb begin
        nxt               = st;
        nxt.press_pending = pending;
        nxt.elapsed_ticks = elapsed;
        ev                = EV_NONE;
        ignored           = 1'b0;
        case (st.phase)
            PH_IDLE: begin
                if (ready) begin
                    nxt.press_pending = 1'b0;
                    nxt.phase         = PH_ONCE;
                end
            end
            PH_ONCE: begin
                if (ready) begin
                    nxt.press_pending = 1'b0;
                    nxt.phase         = PH_TWICE;
                end else if (window_done) begin
                    // a press still inside its debounce time stays pending
                    nxt.single_flag = !st.single_flag;
                    ev              = EV_SINGLE;
                    nxt.phase       = PH_PAUSE;
                end
            end
            PH_TWICE: begin
                if (ready) begin
                    nxt.press_pending = 1'b0;
                    nxt.phase         = PH_THRICE;
                end else if (window_done) begin
                    nxt.press_pending = 1'b0;
                    nxt.double_flag   = !st.double_flag;
                    ev                = EV_DOUBLE;
                    nxt.phase         = PH_PAUSE;
                end
            end
            PH_THRICE: begin
                if (window_done) begin
                    nxt.press_pending = 1'b0;
                    nxt.triple_flag   = !st.triple_flag;
                    ev                = EV_TRIPLE;
                    nxt.phase         = PH_PAUSE;
                end
            end
            default: begin
                // pause: drop presses, return to idle once quiet long enough
                nxt.phase = PH_PAUSE;
                if (pending) begin
                    nxt.press_pending = 1'b0;
                    ignored           = 1'b1;
                end else if (pause_done) begin
                    nxt.phase = PH_IDLE;
                end
            end
        endcase
    end

    assign st_next = nxt;

    assign res.phase           = nxt.phase;
    assign res.single_toggle   = nxt.single_flag;
    assign res.double_toggle   = nxt.double_flag;
    assign res.triple_toggle   = nxt.triple_flag;
    assign res.completed_event = ev;
    assign res.press_ignored   = ignored;

endmodule
`default_nettype wire

/* hdl/multi_press_classifier.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_press_classifier: single / double / triple button-press classifier
//
// Each input word on the s_ channel is one time tick with a button
// falling-edge flag. Each accepted word yields exactly one result word on
// the m_ channel: the phase after the tick, the three toggle flags, the
// press completed this tick and a flag for a press dropped during pause.
// The result is in the output register on the cycle after the input word is
// accepted. Throughput is one word per cycle when the receiver does not
// stall; the whole tick is one pass through the latch, counter compares and
// phase machine between the state registers and the output register.
// When the receiver stalls, the result is held and s_tready drops until
// the result is taken; a new word is taken in the same cycle the held one
// leaves. The cfg_ channel writes the debounce, window and pause times and
// is always ready; write it only while the block is idle.
// Reset (aresetn low, synchronous) restores the default times, returns the
// machine to idle, clears the counter, pending press and toggle flags, and
// empties the output register.
// ----------------------------------------------------------------------------
module multi_press_classifier (
    input  wire                                aclk,
    input  wire                                aresetn,
    // input stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [mpc_pkg::S_DATA_W-1:0]       s_tdata,   // [0] button_edge
    // result stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [2:0] phase, [3] single_toggle, [4] double_toggle, [5] triple_toggle,
    // [7:6] completed_event, [8] press_ignored
    output logic [mpc_pkg::M_DATA_W-1:0]       m_tdata,
    // configuration writes
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [mpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [mpc_pkg::CFG_W-1:0]          cfg_data
);
    import mpc_pkg::*;

    cfg_t    cfg_reg;
    state_t  st_reg;
    state_t  st_next;
    result_t res_next;
    result_t res_reg;
    logic    m_tvalid_reg;
    logic    s_accept;
    logic    m_accept;
    logic    cfg_accept;

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign m_accept   = m_tvalid_reg && m_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RESET;
            cfg_reg.window_ticks   <= WINDOW_RESET;
            cfg_reg.pause_ticks    <= PAUSE_RESET;
        end else if (cfg_accept) begin
            case (cfg_index)
                REG_DEBOUNCE: cfg_reg.debounce_ticks <= cfg_data;
                REG_WINDOW:   cfg_reg.window_ticks   <= cfg_data;
                REG_PAUSE:    cfg_reg.pause_ticks    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // one tick of classification
    mpc_step u_step (
        .st          (st_reg),
        .cfg         (cfg_reg),
        .button_edge (s_tdata[0]),
        .st_next     (st_next),
        .res         (res_next)
    );

    // classifier state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase         <= PH_IDLE;
            st_reg.press_pending <= 1'b0;
            st_reg.elapsed_ticks <= '0;
            st_reg.single_flag   <= 1'b0;
            st_reg.double_flag   <= 1'b0;
            st_reg.triple_flag   <= 1'b0;
        end else if (s_accept) begin
            st_reg <= st_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_accept) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(res_reg);

`ifndef SYNTHESIS
    // a completed press always lands in pause
    a_event_pause: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && res_reg.completed_event != EV_NONE)
        |-> res_reg.phase == PH_PAUSE)
        else $error("completed press without pause phase");

    // a dropped press only happens in pause and never with a completion
    a_ignored_pause: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && res_reg.press_ignored)
        |-> (res_reg.phase == PH_PAUSE && res_reg.completed_event == EV_NONE))
        else $error("press dropped outside pause");

    // every accepted tick produces a result word in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid_reg)
        else $error("accepted tick produced no result");

    // the single flag flips exactly when a single press completes
    a_single_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> ((st_reg.single_flag != $past(st_reg.single_flag))
                      == (res_reg.completed_event == EV_SINGLE)))
        else $error("single flag out of step with completions");
`endif

endmodule
`default_nettype wire

/* verif/multi_press_classifier_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_press_classifier_test: self-checking bench for the press classifier
// A short scripted sequence (reset values, zero debounce, single, double and
// triple gestures, presses dropped during pause, the single-press timeout
// with a press still debouncing, a write to the spare register index) is
// followed by randomized press gestures and noise under several timing
// settings and idling mixes. Every result word is compared field by field
// against an in-bench model of the classifier; a few scripted rows carry
// hand-computed results instead.
// ----------------------------------------------------------------------------
module multi_press_classifier_test;
    import mpc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    // no register lives at this index; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [CFG_W-1:0]     CFG_MAX   = {CFG_W{1'b1}};

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      value;
        logic                  button;
        logic                  pinned;
        result_t               want;
    } row_t;

    typedef struct packed {
        logic    pinned;
        result_t want;
    } pin_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    wire                   s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    wire                   m_tvalid;
    logic                  m_tready  = 1'b0;
    wire  [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    wire                   cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    multi_press_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // classifier model state and its copy of the timing registers
    logic [CFG_W-1:0]       debounce_lim = DEBOUNCE_RESET;
    logic [CFG_W-1:0]       window_lim   = WINDOW_RESET;
    logic [CFG_W-1:0]       pause_lim    = PAUSE_RESET;
    phase_t                 gesture_phase = PH_IDLE;
    logic                   press_held    = 1'b0;
    logic [TIMER_WIDTH-1:0] since_press   = '0;
    logic                   flip_single   = 1'b0;
    logic                   flip_double   = 1'b0;
    logic                   flip_triple   = 1'b0;

    result_t press_results[$];   // results owed by the block, oldest first
    pin_t    pin_queue[$];       // per offered word: hand-computed result, if any
    row_t    press_script[$];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int hold_requests   = 0;
    int hold_taken      = 0;
    int hold_left       = 0;
    int ticks_offered   = 0;
    int words_checked   = 0;
    int mismatches      = 0;
    int settings_run    = 0;
    int singles         = 0;
    int doubles         = 0;
    int triples         = 0;
    int dropped         = 0;
    int quiet_cycles    = 0;

    // one tick of the classifier: latch first, then the phase machine
    function automatic result_t classify_tick(input logic button);
        result_t r;
        logic    counts;
        r = '0;
        r.completed_event = EV_NONE;
        if (button && !press_held) begin
            press_held  = 1'b1;
            since_press = '0;
        end else if (since_press != {TIMER_WIDTH{1'b1}}) begin
            since_press = since_press + TIMER_WIDTH'(1);
        end
        counts = press_held && (since_press >= debounce_lim);
        case (gesture_phase)
            PH_IDLE: begin
                if (counts) begin
                    press_held    = 1'b0;
                    gesture_phase = PH_ONCE;
                end
            end
            PH_ONCE: begin
                if (counts) begin
                    press_held    = 1'b0;
                    gesture_phase = PH_TWICE;
                end else if (since_press >= window_lim) begin
                    // a press still debouncing stays held and is dropped in pause
                    flip_single       = ~flip_single;
                    r.completed_event = EV_SINGLE;
                    gesture_phase     = PH_PAUSE;
                end
            end
            PH_TWICE: begin
                if (counts) begin
                    press_held    = 1'b0;
                    gesture_phase = PH_THRICE;
                end else if (since_press >= window_lim) begin
                    press_held        = 1'b0;
                    flip_double       = ~flip_double;
                    r.completed_event = EV_DOUBLE;
                    gesture_phase     = PH_PAUSE;
                end
            end
            PH_THRICE: begin
                if (since_press >= window_lim) begin
                    press_held        = 1'b0;
                    flip_triple       = ~flip_triple;
                    r.completed_event = EV_TRIPLE;
                    gesture_phase     = PH_PAUSE;
                end
            end
            default: begin
                gesture_phase = PH_PAUSE;
                if (press_held) begin
                    press_held      = 1'b0;
                    r.press_ignored = 1'b1;
                end else if (since_press >= pause_lim) begin
                    gesture_phase = PH_IDLE;
                end
            end
        endcase
        r.phase         = gesture_phase;
        r.single_toggle = flip_single;
        r.double_toggle = flip_double;
        r.triple_toggle = flip_triple;
        return r;
    endfunction

    function automatic result_t outcome(input phase_t ph, input logic s, input logic d,
                                        input logic t, input event_t ev, input logic ign);
        result_t r;
        r.phase           = ph;
        r.single_toggle   = s;
        r.double_toggle   = d;
        r.triple_toggle   = t;
        r.completed_event = ev;
        r.press_ignored   = ign;
        return r;
    endfunction

    // scoreboard: predict on input words, compare on result words
    always @(posedge aclk) begin
        pin_t    pin;
        result_t guess;
        result_t want;
        result_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEBOUNCE: debounce_lim = cfg_data;
                    REG_WINDOW:   window_lim   = cfg_data;
                    REG_PAUSE:    pause_lim    = cfg_data;
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pin   = pin_queue.pop_front();
                guess = classify_tick(s_tdata[0]);
                press_results.push_back(pin.pinned ? pin.want : guess);
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (press_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing expected: %h", $realtime,
                                 m_tdata);
                end else begin
                    want = press_results.pop_front();
                    words_checked++;
                    if (got.phase !== want.phase
                            || got.single_toggle !== want.single_toggle
                            || got.double_toggle !== want.double_toggle
                            || got.triple_toggle !== want.triple_toggle
                            || got.completed_event !== want.completed_event
                            || got.press_ignored !== want.press_ignored) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: word %0d: expected phase %0d flags %b%b%b ",
                                      "event %0d ignored %b, got phase %0d flags %b%b%b ",
                                      "event %0d ignored %b"}, $realtime, words_checked,
                                     want.phase, want.triple_toggle, want.double_toggle,
                                     want.single_toggle, want.completed_event,
                                     want.press_ignored, got.phase, got.triple_toggle,
                                     got.double_toggle, got.single_toggle,
                                     got.completed_event, got.press_ignored);
                    end
                end
                case (got.completed_event)
                    EV_SINGLE: singles++;
                    EV_DOUBLE: doubles++;
                    EV_TRIPLE: triples++;
                    default:   ;
                endcase
                if (got.press_ignored === 1'b1)
                    dropped++;
            end
        end
    end

    // result side: random stalls plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("multi_press_classifier_test: errors");
                $finish;
            end
        end
    end

    // offer one tick word and return at the edge that takes it
    task automatic push_tick(input logic button, input logic pinned, input result_t want);
        pin_t pin;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        pin.pinned = pinned;
        pin.want   = want;
        pin_queue.push_back(pin);
        ticks_offered++;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-1){1'b0}}, button};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // stop offering and let every owed result come out
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (press_results.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic apply_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] win,
                                input logic [CFG_W-1:0] pau);
        settle();
        cfg_put(REG_DEBOUNCE, deb);
        cfg_put(REG_WINDOW, win);
        cfg_put(REG_PAUSE, pau);
        cfg_valid <= 1'b0;
    endtask

    task automatic script_tick(input logic button);
        row_t row;
        row        = '0;
        row.kind   = ROW_TICK;
        row.button = button;
        press_script.push_back(row);
    endtask

    task automatic script_pin(input logic button, input result_t want);
        row_t row;
        row        = '0;
        row.kind   = ROW_TICK;
        row.button = button;
        row.pinned = 1'b1;
        row.want   = want;
        press_script.push_back(row);
    endtask

    task automatic script_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        row_t row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.idx   = idx;
        row.value = value;
        press_script.push_back(row);
    endtask

    // random part: press gestures with random spacing, mixed with noise
    task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] win,
                             input logic [CFG_W-1:0] pau, input int idle_pct,
                             input int stall, input int n_ticks, input bit squeeze);
        int first;
        int dcap;
        int wcap;
        int pcap;
        int presses;
        int k;
        apply_timing(deb, win, pau);
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        settings_run++;
        dcap  = (deb > 30) ? 30 : int'(deb);
        wcap  = (win > 30) ? 30 : int'(win);
        pcap  = (pau > 30) ? 30 : int'(pau);
        first = ticks_offered;
        if (squeeze)
            hold_requests++;
        while (ticks_offered - first < n_ticks) begin
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 8)) push_tick(1'($urandom_range(1)), 1'b0, '0);
            end else begin
                presses = $urandom_range(1, 4);
                for (k = 0; k < presses; k++) begin
                    push_tick(1'b1, 1'b0, '0);
                    repeat ($urandom_range(0, dcap + wcap + 1)) push_tick(1'b0, 1'b0, '0);
                end
                repeat ($urandom_range(0, wcap + pcap + 4)) push_tick(1'b0, 1'b0, '0);
            end
        end
    endtask

    initial begin
        row_t row;
        bit   writing;
        writing = 1'b0;

        // scripted sequence; rows with a pinned result were worked out by hand
        script_pin(1'b0, outcome(PH_IDLE, 1'b0, 1'b0, 1'b0, EV_NONE, 1'b0));
        script_write(REG_DEBOUNCE, '0);
        script_write(REG_WINDOW, 24'd3);
        script_write(REG_PAUSE, 24'd1);
        script_write(REG_SPARE, CFG_MAX);
        // zero debounce: the press counts in the tick it is latched
        script_pin(1'b1, outcome(PH_ONCE, 1'b0, 1'b0, 1'b0, EV_NONE, 1'b0));
        script_tick(1'b0);
        script_tick(1'b0);
        script_pin(1'b0, outcome(PH_PAUSE, 1'b1, 1'b0, 1'b0, EV_SINGLE, 1'b0));
        // press during pause is dropped
        script_pin(1'b1, outcome(PH_PAUSE, 1'b1, 1'b0, 1'b0, EV_NONE, 1'b1));
        script_tick(1'b0);
        // double, back to idle, then triple
        script_tick(1'b1);
        script_tick(1'b1);
        repeat (4) script_tick(1'b0);
        repeat (3) script_tick(1'b1);
        repeat (3) script_tick(1'b0);
        // debounce longer than window: single times out with a press still held
        script_write(REG_DEBOUNCE, 24'd2);
        script_write(REG_WINDOW, 24'd1);
        script_write(REG_PAUSE, '0);
        script_tick(1'b0);
        script_tick(1'b1);
        script_tick(1'b0);
        script_tick(1'b0);
        script_tick(1'b1);
        repeat (3) script_tick(1'b0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (press_script[i]) begin
            row = press_script[i];
            if (row.kind == ROW_WRITE) begin
                if (!writing)
                    settle();
                writing = 1'b1;
                cfg_put(row.idx, row.value);
            end else begin
                if (writing)
                    cfg_valid <= 1'b0;
                writing = 1'b0;
                push_tick(row.button, row.pinned, row.want);
            end
        end

        // timing settings and idling mixes
        run_phase('0, '0, '0, 0, 0, 200, 1'b0);
        run_phase(CFG_W'($urandom_range(3)), CFG_W'($urandom_range(2, 12)),
                  CFG_W'($urandom_range(16)), 74, 0, 300, 1'b0);
        run_phase(CFG_W'($urandom_range(3)), CFG_W'($urandom_range(2, 12)),
                  CFG_W'($urandom_range(16)), 0, 74, 300, 1'b0);
        run_phase(CFG_W'($urandom_range(3)), CFG_W'($urandom_range(2, 12)),
                  CFG_W'($urandom_range(16)), 33, 33, 300, 1'b0);
        run_phase(CFG_W'($urandom_range(5, 12)), CFG_W'($urandom_range(1, 4)),
                  CFG_W'($urandom_range(8)), 0, 0, 250, 1'b1);
        run_phase(CFG_MAX, CFG_MAX, CFG_MAX, 0, 0, 60, 1'b0);
        run_phase(CFG_W'($urandom_range(2)), CFG_W'($urandom_range(1, 8)),
                  CFG_W'($urandom_range(6)), 0, 0, 240, 1'b1);

        settle();
        if (press_results.size() != 0)
            mismatches += press_results.size();
        $display("ran %0d tick words under %0d timing settings, %0d results checked",
                 ticks_offered, settings_run, words_checked);
        $display("gestures seen: %0d single, %0d double, %0d triple; %0d presses dropped",
                 singles, doubles, triples, dropped);
        if (mismatches == 0)
            $display("multi_press_classifier_test: clean");
        else
            $display("multi_press_classifier_test: errors");
        $finish;
    end

endmodule

/* sim.f */
hdl/mpc_pkg.sv
hdl/mpc_step.sv
hdl/multi_press_classifier.sv
verif/multi_press_classifier_test.sv
